// ===== hdl/haqi_pkg.sv =====
// shared types, constants and helpers for the hourly aqi block
// breakpoint tables, fsm state type, divider sizing and the counter memory request
// no dependencies
package haqi_pkg;

    // payload widths
    localparam int SENSOR_W   = 4;
    localparam int SUM_W      = 32;
    localparam int SCOUNT_W   = 12;
    localparam int MEAN_W     = 32;
    localparam int AQI_W      = 13;
    localparam int CODE_W     = 3;
    localparam int LCOUNT_W   = 32;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    // histogram geometry
    localparam int LEVELS              = 7;
    localparam int DEFAULT_NUM_SENSORS = 16;
    localparam logic [CODE_W-1:0] CODE_OUT = 3'd7;

    // interpolation operand widths
    localparam int DIFF_W  = 12;
    localparam int SPANA_W = 10;
    localparam int PROD_W  = DIFF_W + SPANA_W;

    // iterative divider: 32-bit dividend, 12-bit divisor, two quotient bits a cycle
    localparam int DIV_DIVIDEND_W = 32;
    localparam int DIV_DIVISOR_W  = 12;
    localparam int DIV_BITS       = 2;
    localparam int DIV_STEPS      = DIV_DIVIDEND_W / DIV_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // breakpoints in tenths
    localparam logic [AQI_W-1:0] CONC_BP [0:7] = '{
        13'd0, 13'd120, 13'd355, 13'd555, 13'd1505, 13'd2505, 13'd3505, 13'd5505
    };
    localparam logic [AQI_W-1:0] AQI_BP [0:7] = '{
        13'd0, 13'd500, 13'd1000, 13'd1500, 13'd2000, 13'd3000, 13'd4000, 13'd5000
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN,
        ST_SEG,
        ST_MUL,
        ST_ISTART,
        ST_INTERP,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    // read-modify-write request to the counter memory
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [LCOUNT_W-1:0] wr_data;
    } cnt_req_t;

    // first segment whose upper breakpoint lies above the mean
    function automatic logic [CODE_W-1:0] find_seg(input logic [MEAN_W-1:0] mean);
        logic [CODE_W-1:0] code;
        code = CODE_OUT;
        for (int i = 7; i >= 1; i--) begin
            if (mean < MEAN_W'(CONC_BP[i])) begin
                code = CODE_W'(i - 1);
            end
        end
        return code;
    endfunction

endpackage

// ===== hdl/haqi_div.sv =====
// iterative unsigned divider, restoring, two quotient bits per cycle
// serves both the hourly mean and the aqi interpolation
// depends on haqi_pkg
module haqi_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [haqi_pkg::DIV_DIVIDEND_W-1:0] dividend,
    input  logic [haqi_pkg::DIV_DIVISOR_W-1:0]  divisor,
    output logic                                done,
    output logic [haqi_pkg::DIV_DIVIDEND_W-1:0] quotient
);

    localparam int NW = haqi_pkg::DIV_DIVIDEND_W;
    localparam int DW = haqi_pkg::DIV_DIVISOR_W;

    logic [NW-1:0]                  quo_reg, quo_next;
    logic [DW-1:0]                  rem_reg, rem_next;
    logic [DW-1:0]                  dsr_reg;
    logic [haqi_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [DW:0]                    trial;

    // one cycle worth of shift-subtract
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int b = 0; b < haqi_pkg::DIV_BITS; b++)
        begin
            trial    = {rem_next, quo_next[NW-1]};
            quo_next = {quo_next[NW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next    = DW'(trial - {1'b0, dsr_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == haqi_pkg::DIV_CNT_W'(haqi_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/haqi_cnt_mem.sv =====
// per-sensor, per-level counter memory with a clearing sweep after reset
// one port, registered read data, read then write at the same address
// depends on haqi_pkg
module haqi_cnt_mem #(
    parameter int DEPTH = haqi_pkg::DEFAULT_NUM_SENSORS * haqi_pkg::LEVELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  haqi_pkg::cnt_req_t                req,
    input  logic [$clog2(DEPTH)-1:0]          addr,
    output logic [haqi_pkg::LCOUNT_W-1:0]     rd_data,
    output logic                              ready
);

    localparam int AW = $clog2(DEPTH);

    logic [haqi_pkg::LCOUNT_W-1:0] mem [0:DEPTH-1];
    logic [haqi_pkg::LCOUNT_W-1:0] rd_data_reg;
    logic [AW-1:0]                 clr_idx_reg;
    logic                          clearing_reg;

    // sweep every entry to zero once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clearing_reg;

endmodule

// ===== hdl/hourly_aqi_with_level_histogram.sv =====
// top level: hourly pm2.5 mean, aqi interpolation and per-sensor level histogram
// instantiates haqi_div and haqi_cnt_mem; depends on haqi_pkg
//
//  channel | dir | word fields (lsb first)
//  s_*     | in  | sensor_id[3:0], hour_sum[35:4], sample_count[47:36]
//  m_*     | out | mean_tenths[31:0], aqi_tenths[44:32], level_code[47:45],
//          |     | level_count[79:48]
//
// between accept and the next accept, an item that bumps a counter makes
// two passes through the shared 16-step divider (mean, then interpolation) plus
// segment search, multiply, memory read and write-back; out-of-range items skip
// the memory and zero-count items go from accept straight to the done state
// after reset the counter memory is swept to zero with s_tready low; the output
// register lets a result wait while the next word is taken, and the last state
// holds until that register is free
module hourly_aqi_with_level_histogram #(
    parameter int NUM_SENSORS = haqi_pkg::DEFAULT_NUM_SENSORS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sensor_id, hour_sum, sample_count
    input  logic [haqi_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mean_tenths, aqi_tenths, level_code, level_count
    output logic [haqi_pkg::OUT_DATA_W-1:0]     m_tdata
);

    localparam int DEPTH = NUM_SENSORS * haqi_pkg::LEVELS;
    localparam int AW    = $clog2(DEPTH);

    haqi_pkg::state_t state_reg, state_next;

    // input word fields
    logic [haqi_pkg::SENSOR_W-1:0] in_sensor;
    logic [haqi_pkg::SUM_W-1:0]    in_sum;
    logic [haqi_pkg::SCOUNT_W-1:0] in_count;
    logic                          accept;

    // item context
    logic [haqi_pkg::SENSOR_W-1:0] sensor_reg;
    logic [haqi_pkg::MEAN_W-1:0]   mean_reg;
    logic [haqi_pkg::CODE_W-1:0]   seg_reg;
    logic [haqi_pkg::DIFF_W-1:0]   diff_reg;
    logic [haqi_pkg::SPANA_W-1:0]  spana_reg;
    logic [haqi_pkg::PROD_W-1:0]   prod_reg;
    logic [haqi_pkg::AQI_W-1:0]    aqi_reg;
    logic [haqi_pkg::LCOUNT_W-1:0] lc_reg;
    logic [haqi_pkg::CODE_W-1:0]   seg_find;
    logic                          in_range;

    // output register
    logic                            out_valid_reg;
    logic [haqi_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                            out_free;

    // divider hookup
    logic                                div_start;
    logic [haqi_pkg::DIV_DIVIDEND_W-1:0] div_dividend;
    logic [haqi_pkg::DIV_DIVISOR_W-1:0]  div_divisor;
    logic                                div_done;
    logic [haqi_pkg::DIV_DIVIDEND_W-1:0] div_quotient;

    // counter memory hookup
    haqi_pkg::cnt_req_t            mem_req;
    logic [AW-1:0]                 mem_addr;
    logic [haqi_pkg::LCOUNT_W-1:0] mem_rd_data;
    logic                          mem_ready;
    logic [haqi_pkg::LCOUNT_W-1:0] cnt_bumped;

    assign in_sensor = s_tdata[3:0];
    assign in_sum    = s_tdata[35:4];
    assign in_count  = s_tdata[47:36];
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    assign seg_find  = haqi_pkg::find_seg(mean_reg);
    assign in_range  = 32'(sensor_reg) < 32'(NUM_SENSORS);
    assign mem_addr  = AW'(32'(sensor_reg) * 32'(haqi_pkg::LEVELS) + 32'(seg_reg));
    // saturating increment
    assign cnt_bumped = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            haqi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_count == '0) ? haqi_pkg::ST_DONE : haqi_pkg::ST_MEAN;
                end
            end
            haqi_pkg::ST_MEAN:
            begin
                if (div_done)
                begin
                    state_next = haqi_pkg::ST_SEG;
                end
            end
            haqi_pkg::ST_SEG:
            begin
                state_next = (seg_find == haqi_pkg::CODE_OUT) ? haqi_pkg::ST_DONE
                                                              : haqi_pkg::ST_MUL;
            end
            haqi_pkg::ST_MUL:    state_next = haqi_pkg::ST_ISTART;
            haqi_pkg::ST_ISTART: state_next = haqi_pkg::ST_INTERP;
            haqi_pkg::ST_INTERP:
            begin
                if (div_done)
                begin
                    state_next = in_range ? haqi_pkg::ST_READ : haqi_pkg::ST_DONE;
                end
            end
            haqi_pkg::ST_READ:   state_next = haqi_pkg::ST_WRITE;
            haqi_pkg::ST_WRITE:  state_next = haqi_pkg::ST_DONE;
            haqi_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = haqi_pkg::ST_IDLE;
                end
            end
            default:             state_next = haqi_pkg::ST_IDLE;
        endcase
    end

    // control outputs per state
    always_comb
    begin
        s_tready         = 1'b0;
        div_start        = 1'b0;
        div_dividend     = in_sum;
        div_divisor      = in_count;
        mem_req.rd_en    = 1'b0;
        mem_req.wr_en    = 1'b0;
        mem_req.wr_data  = cnt_bumped;
        unique case (state_reg)
            haqi_pkg::ST_IDLE:
            begin
                s_tready  = mem_ready;
                div_start = s_tvalid && mem_ready && (in_count != '0);
            end
            haqi_pkg::ST_ISTART:
            begin
                div_start    = 1'b1;
                div_dividend = haqi_pkg::DIV_DIVIDEND_W'(prod_reg);
                div_divisor  = haqi_pkg::DIV_DIVISOR_W'(haqi_pkg::CONC_BP[seg_reg + 1'b1]
                                                        - haqi_pkg::CONC_BP[seg_reg]);
            end
            haqi_pkg::ST_READ:   mem_req.rd_en = 1'b1;
            haqi_pkg::ST_WRITE:  mem_req.wr_en = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= haqi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == haqi_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            haqi_pkg::ST_IDLE:
            begin
                sensor_reg <= in_sensor;
                // zero count result is all zero with the out-of-range code
                mean_reg   <= '0;
                seg_reg    <= haqi_pkg::CODE_OUT;
                aqi_reg    <= '0;
                lc_reg     <= '0;
            end
            haqi_pkg::ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_reg <= div_quotient;
                end
            end
            haqi_pkg::ST_SEG:
            begin
                seg_reg   <= seg_find;
                diff_reg  <= haqi_pkg::DIFF_W'(mean_reg
                                               - haqi_pkg::MEAN_W'(haqi_pkg::CONC_BP[seg_find]));
                spana_reg <= haqi_pkg::SPANA_W'(haqi_pkg::AQI_BP[seg_find + 1'b1]
                                                - haqi_pkg::AQI_BP[seg_find]);
            end
            haqi_pkg::ST_MUL:
            begin
                prod_reg <= haqi_pkg::PROD_W'(diff_reg) * haqi_pkg::PROD_W'(spana_reg);
            end
            haqi_pkg::ST_INTERP:
            begin
                if (div_done)
                begin
                    aqi_reg <= haqi_pkg::AQI_BP[seg_reg] + haqi_pkg::AQI_W'(div_quotient);
                end
            end
            haqi_pkg::ST_WRITE:
            begin
                lc_reg <= cnt_bumped;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == haqi_pkg::ST_DONE && out_free)
        begin
            out_data_reg <= {lc_reg, seg_reg, aqi_reg, mean_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    haqi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    haqi_cnt_mem #(
        .DEPTH (DEPTH)
    ) u_cnt_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .addr    (mem_addr),
        .rd_data (mem_rd_data),
        .ready   (mem_ready)
    );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for hourly_aqi_with_level_histogram
// streams sensor words into s_*, checks mean, aqi, level and histogram count on m_*
// depends on haqi_pkg and the rtl under hdl/
module testbench;

    localparam int NUM_SENSORS  = 16;
    localparam int RANDOM_WORDS = 950;
    localparam int STALL_LIMIT  = 4000;   // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 60;     // idle margin after the last result
    localparam int QUIET_FROM   = 15000;  // stretch with no idling on either side
    localparam int QUIET_TO     = 22000;
    localparam int HOLD_AT      = 6000;   // receiver backs off here for a long stretch
    localparam int HOLD_CYCLES  = 400;

    // breakpoints in tenths, kept apart from the rtl tables
    localparam int unsigned CONC_EDGE [0:7] = '{0, 120, 355, 555, 1505, 2505, 3505, 5505};
    localparam int unsigned AQI_EDGE  [0:7] = '{0, 500, 1000, 1500, 2000, 3000, 4000, 5000};

    typedef struct {
        logic [haqi_pkg::MEAN_W-1:0]   mean;
        logic [haqi_pkg::AQI_W-1:0]    aqi;
        logic [haqi_pkg::CODE_W-1:0]   code;
        logic [haqi_pkg::LCOUNT_W-1:0] count;
    } aqi_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [haqi_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [haqi_pkg::OUT_DATA_W-1:0] m_tdata;

    logic [haqi_pkg::IN_DATA_W-1:0]  pending_words [$];
    aqi_result_t                     results_due [$];
    logic [haqi_pkg::LCOUNT_W-1:0]   hist_model [0:NUM_SENSORS*haqi_pkg::LEVELS-1];

    int  cyc = 0;
    int  idle_run = 0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  words_in = 0;
    int  results_out = 0;
    int  code_hits [0:7];
    logic word_taken = 1'b0;
    logic quiet;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    hourly_aqi_with_level_histogram #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // mean by truncating division, segment search, exact interpolation, counter bump
    function automatic aqi_result_t predict_hourly_result(
        input logic [haqi_pkg::IN_DATA_W-1:0] w);
        aqi_result_t r;
        logic [haqi_pkg::SENSOR_W-1:0] sensor;
        logic [haqi_pkg::SUM_W-1:0]    sum;
        logic [haqi_pkg::SCOUNT_W-1:0] samples;
        logic [63:0]                   num;
        int unsigned                   seg;
        int unsigned                   idx;
        sensor  = w[3:0];
        sum     = w[35:4];
        samples = w[47:36];
        r.mean  = '0;
        r.aqi   = '0;
        r.code  = haqi_pkg::CODE_OUT;
        r.count = '0;
        if (samples != '0) begin
            r.mean = sum / {20'd0, samples};
            seg = 7;
            for (int i = 7; i >= 1; i--) begin
                if (r.mean < CONC_EDGE[i]) begin
                    seg = i - 1;
                end
            end
            if (seg < 7) begin
                r.code = haqi_pkg::CODE_W'(seg);
                num = 64'(AQI_EDGE[seg+1] - AQI_EDGE[seg]) * 64'(r.mean - CONC_EDGE[seg]);
                r.aqi = haqi_pkg::AQI_W'(AQI_EDGE[seg]
                                         + 32'(num / 64'(CONC_EDGE[seg+1] - CONC_EDGE[seg])));
                if (sensor < NUM_SENSORS) begin
                    idx = sensor * haqi_pkg::LEVELS + seg;
                    if (hist_model[idx] != '1) begin
                        hist_model[idx] = hist_model[idx] + 1'b1;
                    end
                    r.count = hist_model[idx];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_hour(input int unsigned sensor, input logic [31:0] sum,
                                       input int unsigned samples);
        pending_words.push_back({samples[haqi_pkg::SCOUNT_W-1:0], sum,
                                 sensor[haqi_pkg::SENSOR_W-1:0]});
    endfunction

    // sample both channels at the rising edge: check results, then predict new words
    always @(posedge clk) begin
        aqi_result_t want;
        logic in_fire;
        logic out_fire;
        in_fire  = s_tvalid && s_tready;
        out_fire = m_tvalid && m_tready;
        cyc <= cyc + 1;
        word_taken <= in_fire;
        if (out_fire) begin
            results_out++;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected word, mean", m_tdata[31:0], 0);
            end else begin
                want = results_due.pop_front();
                if (m_tdata[31:0] !== want.mean)
                    report_mismatch("mean_tenths", m_tdata[31:0], want.mean);
                if (m_tdata[44:32] !== want.aqi)
                    report_mismatch("aqi_tenths", m_tdata[44:32], want.aqi);
                if (m_tdata[47:45] !== want.code)
                    report_mismatch("level_code", m_tdata[47:45], want.code);
                if (m_tdata[79:48] !== want.count)
                    report_mismatch("level_count", m_tdata[79:48], want.count);
            end
        end
        if (in_fire) begin
            want = predict_hourly_result(s_tdata);
            results_due.push_back(want);
            code_hits[want.code]++;
            words_in++;
        end
        // watchdog: nothing moving for too long means the block is stuck
        if (in_fire || out_fire) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // sender: a new word goes up only once the previous one was taken
    always @(negedge clk) begin
        if (rst_n && (!s_tvalid || word_taken)) begin
            if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 30)) begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random backpressure, one long hold-off so the block fills and stalls s_*
    always @(negedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (cyc == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        int unsigned samples;
        int unsigned mean;
        int unsigned sensor;
        int unsigned pick;
        logic [31:0] sum;

        foreach (hist_model[i]) hist_model[i] = '0;
        foreach (code_hits[i]) code_hits[i] = 0;

        // directed: zero count, huge means, every breakpoint edge, truncation
        queue_hour(0, 32'd0, 0);
        queue_hour(15, 32'hFFFF_FFFF, 0);
        queue_hour(15, 32'hFFFF_FFFF, 1);
        queue_hour(3, 32'hFFFF_FFFF, 4095);
        queue_hour(0, 32'd0, 4095);
        for (int i = 1; i <= 7; i++) begin
            queue_hour(i, CONC_EDGE[i] - 1, 1);
            queue_hour(i + 7, CONC_EDGE[i], 1);
        end
        queue_hour(4, 32'd1199, 10);
        queue_hour(5, 32'd5505 * 7 - 1, 7);
        queue_hour(2, 32'd300, 1);
        queue_hour(2, 32'd300, 1);

        // random: mostly in-range means with random remainders, some noise
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            sensor  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            samples = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16)
                                                  : $urandom_range(1, 4095);
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                mean = $urandom_range(0, 5504);
                sum  = mean * samples + $urandom_range(0, samples - 1);
            end else if (pick < 80) begin
                // straddle a breakpoint
                mean = CONC_EDGE[$urandom_range(1, 7)] + $urandom_range(0, 3) - 2;
                sum  = mean * samples + $urandom_range(0, samples - 1);
            end else if (pick < 90) begin
                sum = $urandom;
            end else if (pick < 95) begin
                sum     = $urandom;
                samples = 0;
            end else begin
                sum     = $urandom;
                samples = 1;
            end
            queue_hour(sensor, sum, samples);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_words.size() == 0 && !s_tvalid);
        wait (results_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words, checked %0d results over %0d cycles", words_in,
                 results_out, cyc);
        $display("level codes 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d", code_hits[0],
                 code_hits[1], code_hits[2], code_hits[3], code_hits[4], code_hits[5],
                 code_hits[6], code_hits[7]);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
